// ===== hw/rtl/phosphor_palette_pixel_mapper_top_assert.svh =====
// Assertion helpers for the palette pixel mapper.
`ifndef PHOSPHOR_PALETTE_PIXEL_MAPPER_TOP_ASSERT_SVH
`define PHOSPHOR_PALETTE_PIXEL_MAPPER_TOP_ASSERT_SVH

// Check a property on every clock edge, reset included.
`define PPM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("palette mapper assertion failed");

// Check a property while out of reset.
`define PPM_ASSERT_RUN(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("palette mapper assertion failed");

`endif

// ===== hw/rtl/ppm_pkg.sv =====
`default_nettype none
package ppm_pkg;

  localparam int CH_W        = 8;
  localparam int RGB_W       = 3 * CH_W;
  localparam int PIX_W       = 16;
  localparam int IDX_W       = 8;
  localparam int BLEND_W     = 7;
  localparam int PROD_W      = CH_W + BLEND_W;
  localparam int RECIP_W     = 13;
  localparam int SCALED_W    = PROD_W + RECIP_W;
  localparam int RECIP_SHIFT = 19;
  localparam int CFG_IDX_W   = 1;

  // x / 100 == (x * 5243) >> 19 for every x below 25600
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam logic [BLEND_W-1:0] BLEND_MAX = 7'd100;

  localparam logic KIND_PALETTE_WRITE = 1'b0;
  localparam logic KIND_PIXEL         = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHOSPHOR_ENABLE = 1'b0,
    CFG_BLEND_PERCENT   = 1'b1
  } cfg_reg_t;

  typedef logic [2:0][CH_W-1:0] rgb_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ppm_ram.sv =====
`default_nettype none
module ppm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/phosphor_palette_pixel_mapper_top.sv =====
// Pixel path from request accept to out_valid: palette read, blend multiply, divide-by-100
// reciprocal and pack. Throughput: one request per cycle, writes and pixels alike, unless a
// held pixel stalls the pipe; the palette is duplicated so both indices read two RAMs at once.
// A palette write takes effect at its accept edge and gives no result.
// Reset (rst_n low, synchronous) clears the pipeline and both config registers; the
// palette contents are not cleared.
`default_nettype none
module phosphor_palette_pixel_mapper_top #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [ppm_pkg::IDX_W-1:0]       in_palette_index,
  input  logic [ppm_pkg::RGB_W-1:0]       in_palette_rgb,
  input  logic [ppm_pkg::IDX_W-1:0]       in_current_color,
  input  logic [ppm_pkg::IDX_W-1:0]       in_previous_color,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ppm_pkg::PIX_W-1:0]       out_pixel_rgb565,
  input  logic                            cfg_we,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppm_pkg::BLEND_W-1:0]     cfg_wdata
);

  import ppm_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [IDX_W:0] LIMIT = (IDX_W + 1)'(PALETTE_ENTRIES);

  logic               phosphor_r;
  logic [BLEND_W-1:0] blend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phosphor_r <= 1'b0;
      blend_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PHOSPHOR_ENABLE: phosphor_r <= cfg_wdata[0];
        CFG_BLEND_PERCENT:   blend_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic adv, accept, wr_en, rd_en;
  logic cur_ok, prev_ok;

  // advance the whole pipe unless a finished pixel is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign wr_en    = accept && (in_kind == KIND_PALETTE_WRITE) &&
                    ({1'b0, in_palette_index} < LIMIT);
  assign rd_en    = accept && (in_kind == KIND_PIXEL);
  assign cur_ok   = {1'b0, in_current_color} < LIMIT;
  assign prev_ok  = {1'b0, in_previous_color} < LIMIT;

  logic [RGB_W-1:0] cur_rd, prev_rd;

  ppm_ram #(.WIDTH(RGB_W), .DEPTH(PALETTE_ENTRIES)) u_ram_cur (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_palette_index[AW-1:0]),
    .wdata (in_palette_rgb),
    .re    (rd_en),
    .raddr (in_current_color[AW-1:0]),
    .rdata (cur_rd)
  );

  ppm_ram #(.WIDTH(RGB_W), .DEPTH(PALETTE_ENTRIES)) u_ram_prev (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_palette_index[AW-1:0]),
    .wdata (in_palette_rgb),
    .re    (rd_en),
    .raddr (in_previous_color[AW-1:0]),
    .rdata (prev_rd)
  );

  // stage 1: palette data arrives
  logic s1_v_r, s1_cur_ok_r, s1_prev_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_cur_ok_r  <= cur_ok;
      s1_prev_ok_r <= prev_ok;
    end
  end

  rgb_t               cur_c, prev_c, lo_c;
  logic [CH_W-1:0]    diff;
  logic [BLEND_W-1:0] weight;
  logic [2:0][PROD_W-1:0] prod;

  always_comb begin
    cur_c  = s1_cur_ok_r  ? rgb_t'(cur_rd)  : '0;
    prev_c = s1_prev_ok_r ? rgb_t'(prev_rd) : '0;
    weight = (blend_r > BLEND_MAX) ? BLEND_MAX : blend_r;
    diff   = '0;
    for (int c = 0; c < 3; c++) begin
      if (phosphor_r) begin
        if (cur_c[c] > prev_c[c]) begin
          diff    = cur_c[c] - prev_c[c];
          lo_c[c] = prev_c[c];
        end else begin
          diff    = prev_c[c] - cur_c[c];
          lo_c[c] = cur_c[c];
        end
        prod[c] = PROD_W'(diff) * PROD_W'(weight);
      end else begin
        lo_c[c] = cur_c[c];
        prod[c] = '0;
      end
    end
  end

  // stage 2: scaled difference and low channel
  logic                   s2_v_r;
  logic [2:0][PROD_W-1:0] s2_prod_r;
  rgb_t                   s2_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod_r <= prod;
      s2_lo_r   <= lo_c;
    end
  end

  logic [2:0][SCALED_W-1:0] scaled;
  rgb_t                     mix;
  logic [PIX_W-1:0]         pix_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      scaled[c] = SCALED_W'(s2_prod_r[c]) * SCALED_W'(RECIP_100);
      mix[c]    = s2_lo_r[c] + scaled[c][RECIP_SHIFT +: CH_W];
    end
    pix_nxt = {mix[2][CH_W-1 -: 5], mix[1][CH_W-1 -: 6], mix[0][CH_W-1 -: 5]};
  end

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r <= pix_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_rgb565 = out_pix_r;

endmodule
`default_nettype wire

// ===== hw/rtl/phosphor_palette_pixel_mapper_checker.sv =====
`default_nettype none
`include "phosphor_palette_pixel_mapper_top_assert.svh"
module phosphor_palette_pixel_mapper_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      in_kind,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [ppm_pkg::PIX_W-1:0] out_pixel_rgb565
);

  import ppm_pkg::*;

  // hold a stalled pixel
  `PPM_ASSERT_RUN(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_pixel_rgb565))

  // input backs up only behind a held result
  `PPM_ASSERT_RUN(a_stall_cause, in_stall |-> out_valid && out_stall)

  // an accepted pixel request reaches out_valid when the pipe does not stall behind it
  `PPM_ASSERT_RUN(a_pixel_latency,
    in_valid && !in_stall && in_kind == KIND_PIXEL ##1 !in_stall ##1 !in_stall |=> out_valid)

  // reset drops any pending result
  `PPM_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid && !in_stall)

endmodule

bind phosphor_palette_pixel_mapper_top phosphor_palette_pixel_mapper_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_kind          (in_kind),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pixel_rgb565 (out_pixel_rgb565)
);
`default_nettype wire

// ===== verif/phosphor_palette_pixel_mapper_top_tb.sv =====
`timescale 1ns / 1ps
module phosphor_palette_pixel_mapper_top_tb;
  import ppm_pkg::*;

  localparam int STUCK_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_kind;
  logic [IDX_W-1:0]     in_palette_index;
  logic [RGB_W-1:0]     in_palette_rgb;
  logic [IDX_W-1:0]     in_current_color;
  logic [IDX_W-1:0]     in_previous_color;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     out_pixel_rgb565;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BLEND_W-1:0]   cfg_wdata;

  // shadow of the block state, updated at each accepted palette write or register write
  logic [RGB_W-1:0]   palette_copy [256];
  bit                 palette_written [256];
  logic [IDX_W-1:0]   written_entries [$];
  bit                 phosphor_on;
  logic [BLEND_W-1:0] blend_weight;

  logic [PIX_W-1:0] expected_pixels [$];
  logic [PIX_W-1:0] oldest_pixel;
  int unsigned      mismatch_count;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      hold_request;
  int unsigned      hold_left;
  int unsigned      stuck_cycles;

  phosphor_palette_pixel_mapper_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_palette_index  (in_palette_index),
    .in_palette_rgb    (in_palette_rgb),
    .in_current_color  (in_current_color),
    .in_previous_color (in_previous_color),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_rgb565  (out_pixel_rgb565),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [PIX_W-1:0] predict_rgb565(logic [IDX_W-1:0] cur_idx,
                                                      logic [IDX_W-1:0] prev_idx);
    logic [RGB_W-1:0] cur_rgb;
    logic [RGB_W-1:0] prev_rgb;
    logic [CH_W-1:0]  mixed [3];
    int unsigned      weight;
    int unsigned      hi;
    int unsigned      lo;
    cur_rgb = palette_copy[cur_idx];
    prev_rgb = palette_copy[prev_idx];
    weight = (blend_weight > BLEND_MAX) ? 32'(BLEND_MAX) : 32'(blend_weight);
    for (int c = 0; c < 3; c++) begin
      mixed[c] = cur_rgb[CH_W*c +: CH_W];
      if (phosphor_on) begin
        hi = 32'((cur_rgb[CH_W*c +: CH_W] > prev_rgb[CH_W*c +: CH_W]) ?
                 cur_rgb[CH_W*c +: CH_W] : prev_rgb[CH_W*c +: CH_W]);
        lo = 32'((cur_rgb[CH_W*c +: CH_W] > prev_rgb[CH_W*c +: CH_W]) ?
                 prev_rgb[CH_W*c +: CH_W] : cur_rgb[CH_W*c +: CH_W]);
        mixed[c] = CH_W'((hi - lo) * weight / 32'(BLEND_MAX) + lo);
      end
    end
    return {mixed[2][7:3], mixed[1][7:2], mixed[0][7:3]};
  endfunction

  function automatic logic [CH_W-1:0] random_channel();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hff;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_written();
    return written_entries[$urandom_range(written_entries.size() - 1)];
  endfunction

  task automatic send_request(logic kind, logic [IDX_W-1:0] pal_idx, logic [RGB_W-1:0] rgb,
                              logic [IDX_W-1:0] cur_idx, logic [IDX_W-1:0] prev_idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= kind;
    in_palette_index  <= pal_idx;
    in_palette_rgb    <= rgb;
    in_current_color  <= cur_idx;
    in_previous_color <= prev_idx;
    do @(posedge clk); while (in_stall);
    if (kind == KIND_PALETTE_WRITE) begin
      palette_copy[pal_idx] = rgb;
      if (!palette_written[pal_idx]) begin
        palette_written[pal_idx] = 1'b1;
        written_entries.push_back(pal_idx);
      end
    end else begin
      expected_pixels.push_back(predict_rgb565(cur_idx, prev_idx));
    end
  endtask

  task automatic write_entry(logic [IDX_W-1:0] idx, logic [RGB_W-1:0] rgb);
    send_request(KIND_PALETTE_WRITE, idx, rgb, IDX_W'($urandom_range(255)),
                 IDX_W'($urandom_range(255)));
  endtask

  task automatic map_pixel(logic [IDX_W-1:0] cur_idx, logic [IDX_W-1:0] prev_idx);
    send_request(KIND_PIXEL, IDX_W'($urandom_range(255)), RGB_W'($urandom), cur_idx, prev_idx);
  endtask

  task automatic random_request();
    if (written_entries.size() == 0 || $urandom_range(99) < 30) begin
      write_entry(IDX_W'($urandom_range(255)),
                  {random_channel(), random_channel(), random_channel()});
    end else begin
      map_pixel(pick_written(), pick_written());
    end
  endtask

  // hold the input idle until every pixel is out, then let the pipeline settle
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_t reg_sel, logic [BLEND_W-1:0] value);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_index <= reg_sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (reg_sel)
      CFG_PHOSPHOR_ENABLE: phosphor_on = value[0];
      CFG_BLEND_PERCENT:   blend_weight = value;
      default: ;
    endcase
  endtask

  task automatic test_plain_lookup();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_register(CFG_PHOSPHOR_ENABLE, 7'd0);
    write_register(CFG_BLEND_PERCENT, 7'd0);
    write_entry(8'h00, 24'h000000);
    write_entry(8'hff, 24'hffffff);
    write_entry(8'h80, 24'h070307);
    write_entry(8'h7f, 24'hf8fcf8);
    write_entry(8'h55, 24'ha55ac3);
    // previous color must not matter with phosphor off
    map_pixel(8'h00, 8'hff);
    map_pixel(8'hff, 8'h00);
    map_pixel(8'h80, 8'h7f);
    map_pixel(8'h7f, 8'h55);
    map_pixel(8'h55, 8'h80);
    // overwrite, then read back in the very next cycle
    write_entry(8'h55, 24'h123456);
    map_pixel(8'h55, 8'h55);
  endtask

  task automatic test_phosphor_blend();
    logic [BLEND_W-1:0] weights [5] = '{7'd0, 7'd100, 7'd127, 7'd1, 7'd50};
    write_register(CFG_PHOSPHOR_ENABLE, 7'd1);
    foreach (weights[i]) begin
      write_register(CFG_BLEND_PERCENT, weights[i]);
      map_pixel(8'hff, 8'h00);
      map_pixel(8'h80, 8'h55);
      map_pixel(8'h55, 8'h55);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = HOLD_CYCLES;
    repeat (40) map_pixel(pick_written(), pick_written());
    wait_results_drained();
    recv_stall_pct = 50;
    repeat (20) random_request();
  endtask

  task automatic test_random_traffic();
    bit                 phos_set [8]   = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    logic [BLEND_W-1:0] blend_set [8]  = '{7'd0, 7'd100, 7'd37, 7'd0, 7'd127, 7'd127, 7'd64,
                                           7'd1};
    int unsigned        send_pct [4]   = '{0, 84, 0, 15};
    int unsigned        recv_pct [4]   = '{0, 0, 84, 15};
    for (int p = 0; p < 8; p++) begin
      write_register(CFG_PHOSPHOR_ENABLE, {6'($urandom_range(63)) & 6'd0, phos_set[p]});
      write_register(CFG_BLEND_PERCENT, (p == 6) ? 7'($urandom_range(127)) : blend_set[p]);
      send_idle_pct = send_pct[p % 4];
      recv_stall_pct = recv_pct[p % 4];
      repeat (170) random_request();
    end
  endtask

  // receiver: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_request != 0) begin
      hold_left = hold_request - 1;
      hold_request = 0;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: pixel expected none, actual %h", $time, out_pixel_rgb565);
        mismatch_count++;
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        if (out_pixel_rgb565 !== oldest_pixel) begin
          $display("%0t: pixel expected %h, actual %h", $time, oldest_pixel, out_pixel_rgb565);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    in_valid          = 1'b0;
    in_kind           = KIND_PALETTE_WRITE;
    in_palette_index  = '0;
    in_palette_rgb    = '0;
    in_current_color  = '0;
    in_previous_color = '0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_PHOSPHOR_ENABLE;
    cfg_wdata         = '0;
    phosphor_on       = 1'b0;
    blend_weight      = '0;
    mismatch_count    = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_request      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_lookup();
    test_phosphor_blend();
    test_backpressure();
    test_random_traffic();
    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
